@@ hw/rtl/ps2mct_pkg.sv @@
// shared types, constants and helpers for the ps2 mouse cell cursor tracker
`default_nettype none

package ps2mct_pkg;

   // field widths
   localparam int DATA_W  = 8;
   localparam int SET_W   = 11;
   localparam int CELL_W  = 8;
   localparam int BTN_W   = 3;
   localparam int KIND_W  = 2;
   localparam int IDX_W   = 2;
   localparam int CFG_W   = 8;

   // arithmetic widths
   localparam int DELTA_W = 10;   // 9-bit delta, y negated
   localparam int SUM_W   = 11;   // remainder plus delta
   localparam int REM_W   = 9;    // signed remainder
   localparam int QUO_W   = SUM_W + 1;
   localparam int POS_W   = 13;   // cursor plus quotient before clamp
   localparam int NUM_EVT = 4;    // move plus three buttons

   // csr port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // flags byte bits
   localparam int FLAG_SYNC_BIT  = 3;
   localparam int FLAG_XSIGN_BIT = 4;
   localparam int FLAG_YSIGN_BIT = 5;

   // reset values
   localparam logic [CFG_W-1:0]  COLUMNS_RST = 8'd80;
   localparam logic [CFG_W-1:0]  ROWS_RST    = 8'd25;
   localparam logic [CFG_W-1:0]  DIVX_RST    = 8'd9;
   localparam logic [CFG_W-1:0]  DIVY_RST    = 8'd15;
   localparam logic [CELL_W-1:0] COL_RST     = 8'd40;
   localparam logic [CELL_W-1:0] ROW_RST     = 8'd12;

   // operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_SET  = 1'b1;

   // event kinds
   localparam logic [KIND_W-1:0] EVT_MOVE    = 2'd0;
   localparam logic [KIND_W-1:0] EVT_PRESS   = 2'd1;
   localparam logic [KIND_W-1:0] EVT_RELEASE = 2'd2;

   // register indexes
   localparam logic [1:0] REG_COLUMNS = 2'd0;
   localparam logic [1:0] REG_ROWS    = 2'd1;
   localparam logic [1:0] REG_DIVX    = 2'd2;
   localparam logic [1:0] REG_DIVY    = 2'd3;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIVIDE,
      B_APPLY,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] columns;
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] div_x;
      logic [CFG_W-1:0] div_y;
   } cfg_type;

   typedef struct packed {
      logic                      is_set;
      logic [BTN_W-1:0]          buttons;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic signed [SET_W-1:0]   set_x;
      logic signed [SET_W-1:0]   set_y;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] event_kind;
      logic [IDX_W-1:0]  button_index;
      logic [CELL_W-1:0] cursor_x;
      logic [CELL_W-1:0] cursor_y;
      logic [BTN_W-1:0]  button_bits;
      logic              last;
   } evt_type;

   // clamp a signed position into 0 .. count-1, zero count acts as one
   function automatic logic [CELL_W-1:0] clamp_cell(input logic signed [POS_W-1:0] v,
                                                    input logic [CFG_W-1:0] count);
      logic [CELL_W-1:0]        hi;
      logic signed [POS_W-1:0]  hi_ext;
      logic [CELL_W-1:0]        res;
      hi     = (count == '0) ? '0 : count - 1'b1;
      hi_ext = $signed({{(POS_W-CELL_W){1'b0}}, hi});
      if (v < 0) begin
         res = '0;
      end else if (v > hi_ext) begin
         res = hi;
      end else begin
         res = v[CELL_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ps2mct_req_if.sv @@
// request channel: controller bytes and set-position words
`default_nettype none

interface ps2mct_req_if import ps2mct_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic [DATA_W-1:0]       data_byte;
   logic                    from_aux;
   logic signed [SET_W-1:0] set_x;
   logic signed [SET_W-1:0] set_y;

   modport source (output valid, operation, data_byte, from_aux, set_x, set_y,
                   input ready);
   modport sink   (input valid, operation, data_byte, from_aux, set_x, set_y,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ps2mct_rsp_if.sv @@
// response channel: cursor and button events
`default_nettype none

interface ps2mct_rsp_if import ps2mct_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] event_kind;
   logic [IDX_W-1:0]  button_index;
   logic [CELL_W-1:0] cursor_x;
   logic [CELL_W-1:0] cursor_y;
   logic [BTN_W-1:0]  button_bits;
   logic              last;

   modport source (output valid, event_kind, button_index, cursor_x, cursor_y,
                   button_bits, last, input ready);
   modport sink   (input valid, event_kind, button_index, cursor_x, cursor_y,
                   button_bits, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ps2mct_front.sv @@
// front end: packet assembly, filtering and command building
`default_nettype none

module ps2mct_front import ps2mct_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   ps2mct_req_if.sink    req_ch,
   input  wire logic     q_full,
   output logic          q_push,
   output cmd_type       q_cmd
);

   logic [1:0]        phase_ff, phase_in;
   logic [DATA_W-1:0] held_ff [2];
   logic              accept;
   logic              is_aux_byte;
   logic              store_byte;
   logic [DATA_W-1:0] flags;
   logic [DELTA_W-1:0] dy_raw;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_aux_byte  = accept && (req_ch.operation == OP_BYTE) && req_ch.from_aux;
   assign store_byte   = is_aux_byte && (phase_ff < 2'd2);
   assign flags        = held_ff[0];

   always_comb begin
      phase_in = phase_ff;
      if (is_aux_byte) begin
         phase_in = store_byte ? phase_ff + 2'd1 : 2'd0;
      end
   end

   // third byte with sync bit set completes a packet
   assign dy_raw = {{(DELTA_W-DATA_W){flags[FLAG_YSIGN_BIT]}}, req_ch.data_byte};

   always_comb begin
      q_cmd.is_set  = (req_ch.operation == OP_SET);
      q_cmd.buttons = flags[BTN_W-1:0];
      q_cmd.dx      = $signed({{(DELTA_W-DATA_W){flags[FLAG_XSIGN_BIT]}}, held_ff[1]});
      q_cmd.dy      = -$signed(dy_raw);
      q_cmd.set_x   = req_ch.set_x;
      q_cmd.set_y   = req_ch.set_y;
      q_push = accept && ((req_ch.operation == OP_SET) ||
               (is_aux_byte && !store_byte && flags[FLAG_SYNC_BIT]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_byte) begin
         held_ff[phase_ff[0]] <= req_ch.data_byte;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ps2mct_queue.sv @@
// short command queue between front and back
`default_nettype none

module ps2mct_queue import ps2mct_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ps2mct_div.sv @@
// serial signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none

module ps2mct_div import ps2mct_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [SUM_W-1:0] dividend,
   input  wire logic [CFG_W-1:0]        divisor,
   output logic                         done,
   output logic signed [QUO_W-1:0]      quotient,
   output logic signed [REM_W-1:0]      remainder
);

   localparam int MAG_W = SUM_W;
   localparam int CNT_W = $clog2(MAG_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [CFG_W-1:0] rem_ff, rem_in;
   logic [CFG_W-1:0] dvs_ff, dvs_in;
   logic             neg_ff, neg_in;
   logic [CFG_W:0]   trial;
   logic [CFG_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[MAG_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend[SUM_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);
         rem_in  = '0;
         dvs_in  = (divisor == '0) ? CFG_W'(1) : divisor;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_in = fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
         quo_in = {quo_ff[MAG_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // both results take the sign of the dividend
   assign done      = done_ff;
   assign quotient  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign remainder = neg_ff ? -$signed({1'b0, rem_ff}) : $signed({1'b0, rem_ff});

endmodule

`default_nettype wire

@@ hw/rtl/ps2mct_back.sv @@
// back end: remainder division, cursor and button update, event output
`default_nettype none

module ps2mct_back import ps2mct_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   ps2mct_rsp_if.source rsp_ch
);

   back_state_type state_ff, state_in;

   logic signed [REM_W-1:0] rem_x_ff, rem_x_in;
   logic signed [REM_W-1:0] rem_y_ff, rem_y_in;
   logic [CELL_W-1:0]       col_ff, col_in;
   logic [CELL_W-1:0]       row_ff, row_in;
   logic [BTN_W-1:0]        btn_ff, btn_in;
   logic [BTN_W-1:0]        new_btn_ff, new_btn_in;
   logic [NUM_EVT-1:0]      pend_ff, pend_in;
   evt_type                 out_ff, out_in;
   logic                    out_valid_ff, out_valid_in;

   logic                    div_start;
   logic                    emit_load;
   logic                    slot_free;
   logic                    x_done, y_done;
   logic signed [QUO_W-1:0] qx, qy;
   logic signed [REM_W-1:0] rx, ry;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic                    move;
   logic [BTN_W-1:0]        changed;
   logic [NUM_EVT-1:0]      apply_mask;
   logic [NUM_EVT-1:0]      pick;
   logic [NUM_EVT-1:0]      rest;
   logic [CELL_W-1:0]       hi_col;

   assign sum_x = SUM_W'(rem_x_ff) + SUM_W'(q_cmd.dx);
   assign sum_y = SUM_W'(rem_y_ff) + SUM_W'(q_cmd.dy);

   ps2mct_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (sum_x),
      .divisor   (cfg.div_x),
      .done      (x_done),
      .quotient  (qx),
      .remainder (rx)
   );

   ps2mct_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (sum_y),
      .divisor   (cfg.div_y),
      .done      (y_done),
      .quotient  (qy),
      .remainder (ry)
   );

   assign slot_free  = !out_valid_ff || rsp_ch.ready;
   assign move       = (qx != '0) || (qy != '0);
   assign changed    = btn_ff ^ new_btn_ff;
   assign apply_mask = {changed, move};
   assign pick       = pend_ff & (~pend_ff + 1'b1);   // lowest pending event
   assign rest       = pend_ff & ~pick;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid && !q_cmd.is_set) begin
               state_in = B_DIVIDE;
            end
         end
         B_DIVIDE: begin
            if (x_done) begin
               state_in = B_APPLY;
            end
         end
         B_APPLY: begin
            state_in = (apply_mask != '0) ? B_EMIT : B_IDLE;
         end
         B_EMIT: begin
            if (slot_free && (rest == '0)) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      emit_load = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            q_pop     = q_valid;
            div_start = q_valid && !q_cmd.is_set;
         end
         B_DIVIDE, B_APPLY: begin
         end
         B_EMIT: begin
            emit_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      rem_x_in   = rem_x_ff;
      rem_y_in   = rem_y_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      btn_in     = btn_ff;
      new_btn_in = new_btn_ff;
      pend_in    = pend_ff;
      out_in     = out_ff;
      if (q_pop && q_cmd.is_set) begin
         col_in = clamp_cell(POS_W'(q_cmd.set_x), cfg.columns);
         row_in = clamp_cell(POS_W'(q_cmd.set_y), cfg.rows);
      end
      if (div_start) begin
         new_btn_in = q_cmd.buttons;
      end
      if (state_ff == B_APPLY) begin
         rem_x_in = rx;
         rem_y_in = ry;
         btn_in   = new_btn_ff;
         pend_in  = apply_mask;
         if (move) begin
            col_in = clamp_cell($signed({{(POS_W-CELL_W){1'b0}}, col_ff}) + POS_W'(qx),
                                cfg.columns);
            row_in = clamp_cell($signed({{(POS_W-CELL_W){1'b0}}, row_ff}) + POS_W'(qy),
                                cfg.rows);
         end
      end
      if (emit_load) begin
         pend_in             = rest;
         out_in.cursor_x     = col_ff;
         out_in.cursor_y     = row_ff;
         out_in.button_bits  = btn_ff;
         out_in.last         = (rest == '0);
         out_in.event_kind   = EVT_MOVE;
         out_in.button_index = '0;
         for (int i = 0; i < BTN_W; i++) begin
            if (pick[i+1]) begin
               out_in.event_kind   = btn_ff[i] ? EVT_PRESS : EVT_RELEASE;
               out_in.button_index = IDX_W'(i);
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         rem_x_ff     <= '0;
         rem_y_ff     <= '0;
         col_ff       <= COL_RST;
         row_ff       <= ROW_RST;
         btn_ff       <= '0;
         pend_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         rem_x_ff     <= rem_x_in;
         rem_y_ff     <= rem_y_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         btn_ff       <= btn_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      new_btn_ff <= new_btn_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.event_kind   = out_ff.event_kind;
   assign rsp_ch.button_index = out_ff.button_index;
   assign rsp_ch.cursor_x     = out_ff.cursor_x;
   assign rsp_ch.cursor_y     = out_ff.cursor_y;
   assign rsp_ch.button_bits  = out_ff.button_bits;
   assign rsp_ch.last         = out_ff.last;

   assign hi_col = (cfg.columns == '0) ? '0 : cfg.columns - 1'b1;

`ifndef ASSERT_OFF
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      x_done == y_done)
      else $error("x and y dividers out of step");

   a_packet_divides: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE && q_valid && !q_cmd.is_set) |=> (state_ff == B_DIVIDE))
      else $error("packet popped without starting the divide");

   a_emit_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EMIT) |-> (pend_ff != '0))
      else $error("emit state with no pending event");

   a_cursor_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_APPLY && move) |=> (col_ff <= hi_col))
      else $error("cursor column beyond range after a move");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ps2_mouse_cell_cursor_tracker.sv @@
// top level: ps2 mouse packet decoder driving a clamped text-cell cursor
//
// req_ch carries one word per controller byte (operation = byte) or per
// set-position request (operation = set). bytes not flagged as aux are
// dropped; three aux bytes form a packet, and packets without the sync
// bit are dropped whole. a set-position word clamps and places the
// cursor and produces no event.
// rsp_ch carries the events of a packet: a move event if the divided x or
// y step is nonzero, then one press or release event per changed button (left,
// right, middle), with last set on the final one.
// a byte or set-position word is taken by the front end while the queue
// is not full; a packet is popped from the queue, run through the serial
// dividers (11 quotient bits, then the done flag), used to update cursor
// and buttons, then its events go in order into the output register,
// each as soon as the register is free.
// a two-entry command queue decouples front and back, so bytes keep
// being taken while a packet is divided or its events wait.
// when rsp_ch stalls, the event holds in the output register and the
// back end waits; once the queue fills, req_ch.ready drops.
// reset (synchronous) restores registers to 80 columns, 25 rows, divisors
// 9 and 15, cursor 40/12, no buttons, zero remainders, empty queue.
`default_nettype none

module ps2_mouse_cell_cursor_tracker import ps2mct_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ps2mct_req_if.sink                 req_ch,
   ps2mct_rsp_if.source               rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [1:0] csr_index;

   // command queue hookup
   logic    q_push, q_full, q_pop, q_valid;
   cmd_type q_push_cmd, q_head_cmd;

   // csr block: register i at byte address 4*i
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_COLUMNS: cfg_in.columns = csr_pwdata[CFG_W-1:0];
            REG_ROWS:    cfg_in.rows    = csr_pwdata[CFG_W-1:0];
            REG_DIVX:    cfg_in.div_x   = csr_pwdata[CFG_W-1:0];
            REG_DIVY:    cfg_in.div_y   = csr_pwdata[CFG_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_COLUMNS: csr_prdata = CSR_DATA_W'(cfg_ff.columns);
         REG_ROWS:    csr_prdata = CSR_DATA_W'(cfg_ff.rows);
         REG_DIVX:    csr_prdata = CSR_DATA_W'(cfg_ff.div_x);
         REG_DIVY:    csr_prdata = CSR_DATA_W'(cfg_ff.div_y);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns <= COLUMNS_RST;
         cfg_ff.rows    <= ROWS_RST;
         cfg_ff.div_x   <= DIVX_RST;
         cfg_ff.div_y   <= DIVY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: packet assembly
   ps2mct_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_push_cmd)
   );

   // decoupling queue
   ps2mct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd)
   );

   // back end: divide, update, emit
   ps2mct_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_cmd   (q_head_cmd),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the ps2 mouse cell cursor tracker against a local decoder
module testbench;
   import ps2mct_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 64;    // up to three eventless commands in flight
   localparam int PHASE_WORDS   = 66;
   localparam int LONG_HOLD     = 300;
   localparam int HOLD_AT_WORD  = 250;
   localparam int REPORT_MAX    = 10;

   // one word of the request channel
   typedef struct packed {
      logic                    operation;
      logic [DATA_W-1:0]       data_byte;
      logic                    from_aux;
      logic signed [SET_W-1:0] set_x;
      logic signed [SET_W-1:0] set_y;
   } ctl_word_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ps2mct_req_if req_bus ();
   ps2mct_rsp_if rsp_bus ();

   ps2_mouse_cell_cursor_tracker uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // local copy of the decoder: registers and packet state
   logic [CFG_W-1:0]  cfg_columns;
   logic [CFG_W-1:0]  cfg_rows;
   logic [CFG_W-1:0]  cfg_div_x;
   logic [CFG_W-1:0]  cfg_div_y;
   int                pkt_phase;
   logic [7:0]        pkt_bytes [2];
   int                rem_x;
   int                rem_y;
   logic [CELL_W-1:0] cur_col;
   logic [CELL_W-1:0] cur_row;
   logic [BTN_W-1:0]  btn_held;

   evt_type      predicted_events [$];   // events still owed by the block, oldest first
   ctl_word_type outbound_words [$];     // words waiting to be offered on the request channel

   logic idle_on      = 1'b0;   // random gaps on both channels
   logic offer_taken  = 1'b0;   // request word accepted at the last rising edge
   int   send_gap     = 0;
   int   stall_left   = 0;
   int   hold_left    = 0;
   logic hold_done    = 1'b0;
   int   words_taken  = 0;
   int   bad_events   = 0;
   int   cycle_count  = 0;

   // clock with a period of 2
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // gap length: mostly none, some short, a few long
   function automatic int draw_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // clamp a signed cell position into 0 .. count-1, a zero count acting as one
   function automatic logic [CELL_W-1:0] fit_cell(input int v, input logic [CFG_W-1:0] count);
      int hi;
      hi = (count == 0) ? 0 : int'(count) - 1;
      if (v < 0) return '0;
      if (v > hi) return CELL_W'(hi);
      return CELL_W'(v);
   endfunction

   function automatic evt_type make_event(input logic [KIND_W-1:0] kind,
                                          input logic [IDX_W-1:0] idx);
      evt_type e;
      e.event_kind   = kind;
      e.button_index = idx;
      e.cursor_x     = cur_col;
      e.cursor_y     = cur_row;
      e.button_bits  = btn_held;
      e.last         = 1'b0;
      return e;
   endfunction

   // advance the local decoder by one accepted word and queue the events it owes
   task automatic decode_word(input ctl_word_type w);
      logic [7:0]       flags;
      logic [BTN_W-1:0] old_btn;
      int               dx, dy, sx, sy, qx, qy, dvx, dvy, b;
      evt_type          found [$];
      if (w.operation == OP_SET) begin
         // set position leaves packet framing, remainders and buttons alone
         cur_col = fit_cell(int'($signed(w.set_x)), cfg_columns);
         cur_row = fit_cell(int'($signed(w.set_y)), cfg_rows);
      end else if (w.from_aux) begin
         if (pkt_phase < 2) begin
            pkt_bytes[pkt_phase] = w.data_byte;
            pkt_phase++;
         end else begin
            pkt_phase = 0;
            flags = pkt_bytes[0];
            // no sync bit: the whole packet is dropped
            if (flags[FLAG_SYNC_BIT]) begin
               // 9-bit deltas from the sign flags, y flipped to grow downward
               dx  = int'(pkt_bytes[1]) - (flags[FLAG_XSIGN_BIT] ? 256 : 0);
               dy  = (flags[FLAG_YSIGN_BIT] ? 256 : 0) - int'(w.data_byte);
               dvx = (cfg_div_x == 0) ? 1 : int'(cfg_div_x);
               dvy = (cfg_div_y == 0) ? 1 : int'(cfg_div_y);
               sx  = rem_x + dx;
               sy  = rem_y + dy;
               // integer divide truncates toward zero, remainder keeps the sign
               qx  = sx / dvx;
               qy  = sy / dvy;
               rem_x = sx % dvx;
               rem_y = sy % dvy;
               old_btn  = btn_held;
               btn_held = flags[BTN_W-1:0];
               if (qx != 0 || qy != 0) begin
                  cur_col = fit_cell(int'(cur_col) + qx, cfg_columns);
                  cur_row = fit_cell(int'(cur_row) + qy, cfg_rows);
                  found.push_back(make_event(EVT_MOVE, '0));
               end
               // left, right, middle in that order
               for (b = 0; b < BTN_W; b++) begin
                  if (!old_btn[b] && btn_held[b]) begin
                     found.push_back(make_event(EVT_PRESS, IDX_W'(b)));
                  end else if (old_btn[b] && !btn_held[b]) begin
                     found.push_back(make_event(EVT_RELEASE, IDX_W'(b)));
                  end
               end
               if (found.size() > 0) found[found.size() - 1].last = 1'b1;
               foreach (found[k]) predicted_events.push_back(found[k]);
            end
         end
      end
   endtask

   // set-position fields of a byte word are don't-care, so they carry noise
   task automatic push_byte(input logic [7:0] data, input logic aux);
      ctl_word_type w;
      w.operation = OP_BYTE;
      w.data_byte = data;
      w.from_aux  = aux;
      w.set_x     = SET_W'($urandom);
      w.set_y     = SET_W'($urandom);
      outbound_words.push_back(w);
   endtask

   // likewise data_byte and from_aux are ignored on a set-position word
   task automatic push_set(input logic signed [SET_W-1:0] x, input logic signed [SET_W-1:0] y);
      ctl_word_type w;
      w.operation = OP_SET;
      w.data_byte = 8'($urandom);
      w.from_aux  = 1'($urandom);
      w.set_x     = x;
      w.set_y     = y;
      outbound_words.push_back(w);
   endtask

   task automatic push_packet(input logic [7:0] flags, input logic [7:0] x, input logic [7:0] y);
      push_byte(flags, 1'b1);
      push_byte(x, 1'b1);
      push_byte(y, 1'b1);
   endtask

   // requested position: extremes, edges, on-screen values or anything at all
   function automatic logic signed [SET_W-1:0] random_set();
      case ($urandom_range(0, 5))
         0:       return -SET_W'(1024);
         1:       return SET_W'(1023);
         2:       return -SET_W'(1);
         3:       return SET_W'($urandom_range(0, 90));
         default: return SET_W'($urandom);
      endcase
   endfunction

   // movement byte: mostly small steps either way, sometimes anything
   function automatic logic [7:0] random_delta();
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 24));
      return 8'(-$urandom_range(1, 24));
   endfunction

   // mostly well-formed packets with random content, the rest noise:
   // set-position words, foreign bytes, stray aux bytes and unsynced packets
   task automatic queue_random_words(input int count);
      int         made, pick;
      logic [7:0] flags, x, y;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            push_set(random_set(), random_set());
            made++;
         end else if (pick < 14) begin
            push_byte(8'($urandom), 1'b0);
         end else if (pick < 18) begin
            // a lone aux byte shifts the framing until sync drops catch up
            push_byte(8'($urandom), 1'b1);
            made++;
         end else begin
            x = random_delta();
            y = random_delta();
            flags = 8'($urandom);
            flags[FLAG_SYNC_BIT] = (pick >= 22);
            // sign flags usually agree with the byte so the step stays small
            if ($urandom_range(0, 3) != 0) flags[FLAG_XSIGN_BIT] = x[7];
            if ($urandom_range(0, 3) != 0) flags[FLAG_YSIGN_BIT] = y[7];
            push_byte(flags, 1'b1);
            if ($urandom_range(0, 7) == 0) push_byte(8'($urandom), 1'b0);
            push_byte(x, 1'b1);
            if ($urandom_range(0, 15) == 0) push_set(random_set(), random_set());
            push_byte(y, 1'b1);
            made += 3;
         end
      end
   endtask

   // apb write: setup cycle, then access cycle, register taken at the edge with pready
   task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_COLUMNS: cfg_columns = value;
         REG_ROWS:    cfg_rows    = value;
         REG_DIVX:    cfg_div_x   = value;
         REG_DIVY:    cfg_div_y   = value;
         default:     ;
      endcase
   endtask

   // wait until every word is taken and every event is in, then let the
   // back end finish any packet or set-position word that owes no event
   task automatic wait_drained();
      do @(posedge clock);
      while (outbound_words.size() > 0 || req_bus.valid || predicted_events.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver: inputs change at the falling edge, next word follows an
   // accepted one without valid dropping unless a gap was drawn
   always @(negedge clock) begin
      ctl_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || offer_taken) begin
         if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap--;
         end else if (outbound_words.size() > 0) begin
            w = outbound_words.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.operation <= w.operation;
            req_bus.data_byte <= w.data_byte;
            req_bus.from_aux  <= w.from_aux;
            req_bus.set_x     <= w.set_x;
            req_bus.set_y     <= w.set_y;
            send_gap = draw_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // event receiver: random stalls, plus one long hold-off while the sender
   // keeps offering, so the command queue fills and request ready drops
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && words_taken >= HOLD_AT_WORD) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = draw_gap();
      end
   end

   // monitor: both handshakes sampled at the rising edge
   always @(posedge clock) begin
      ctl_word_type w;
      evt_type      got, want;
      offer_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         w.operation = req_bus.operation;
         w.data_byte = req_bus.data_byte;
         w.from_aux  = req_bus.from_aux;
         w.set_x     = req_bus.set_x;
         w.set_y     = req_bus.set_y;
         decode_word(w);
         words_taken++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.event_kind   = rsp_bus.event_kind;
         got.button_index = rsp_bus.button_index;
         got.cursor_x     = rsp_bus.cursor_x;
         got.cursor_y     = rsp_bus.cursor_y;
         got.button_bits  = rsp_bus.button_bits;
         got.last         = rsp_bus.last;
         if (predicted_events.size() == 0) begin
            bad_events++;
            if (bad_events <= REPORT_MAX)
               $display("unexpected event: kind %0d button %0d x %0d y %0d bits %b last %b",
                        got.event_kind, got.button_index, got.cursor_x, got.cursor_y,
                        got.button_bits, got.last);
         end else begin
            want = predicted_events.pop_front();
            if (got.event_kind !== want.event_kind || got.button_index !== want.button_index ||
                got.cursor_x !== want.cursor_x || got.cursor_y !== want.cursor_y ||
                got.button_bits !== want.button_bits || got.last !== want.last) begin
               bad_events++;
               if (bad_events <= REPORT_MAX)
                  $display({"event mismatch: expected kind %0d button %0d x %0d y %0d bits %b",
                            " last %b, got kind %0d button %0d x %0d y %0d bits %b last %b"},
                           want.event_kind, want.button_index, want.cursor_x, want.cursor_y,
                           want.button_bits, want.last, got.event_kind, got.button_index,
                           got.cursor_x, got.cursor_y, got.button_bits, got.last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // reset, directed words, then phases of random words under changing registers
   initial begin : run
      int ph;
      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_BYTE;
      req_bus.data_byte = '0;
      req_bus.from_aux  = 1'b0;
      req_bus.set_x     = '0;
      req_bus.set_y     = '0;
      rsp_bus.ready     = 1'b0;
      cfg_columns = COLUMNS_RST;
      cfg_rows    = ROWS_RST;
      cfg_div_x   = DIVX_RST;
      cfg_div_y   = DIVY_RST;
      pkt_phase   = 0;
      rem_x       = 0;
      rem_y       = 0;
      cur_col     = COL_RST;
      cur_row     = ROW_RST;
      btn_held    = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part under the reset registers, no idling
      push_set(-1024, -1024);                // clamps to the top left corner
      push_set(1023, 1023);                  // clamps to the bottom right corner
      push_byte(8'hFF, 1'b0);                // keyboard byte, ignored
      push_packet(8'h09, 8'hFF, 8'h00);      // largest positive x, left pressed
      push_byte(8'h3F, 1'b1);                // both sign flags, all buttons
      push_set(40, 12);                      // set position in mid packet
      push_byte(8'h00, 1'b1);                // x = -256
      push_byte(8'h00, 1'b1);                // y = -256, flipped to +256
      push_packet(8'h07, 8'h55, 8'hAA);      // no sync bit: dropped
      push_packet(8'h08, 8'h00, 8'h00);      // all three buttons released
      push_packet(8'h0F, 8'h80, 8'h80);      // move plus three presses
      push_packet(8'hC8, 8'h01, 8'h01);      // overflow bits set, small step
      push_set(0, 0);
      push_packet(8'h38, 8'hFF, 8'hFF);      // minus one each way from the corner
      queue_random_words(PHASE_WORDS);
      wait_drained();

      for (ph = 1; ph <= 5; ph++) begin
         idle_on = (ph != 3);
         case (ph)
            1: begin
               write_reg(REG_COLUMNS, 8'd255);
               write_reg(REG_ROWS,    8'd255);
               write_reg(REG_DIVX,    8'd1);
               write_reg(REG_DIVY,    8'd1);
            end
            2: begin
               // single cell screen, slowest cursor
               write_reg(REG_COLUMNS, 8'd1);
               write_reg(REG_ROWS,    8'd1);
               write_reg(REG_DIVX,    8'd255);
               write_reg(REG_DIVY,    8'd255);
            end
            default: begin
               write_reg(REG_COLUMNS, 8'($urandom_range(1, 255)));
               write_reg(REG_ROWS,    8'($urandom_range(1, 255)));
               write_reg(REG_DIVX,    8'($urandom_range(1, 20)));
               write_reg(REG_DIVY,    8'($urandom_range(1, 255)));
            end
         endcase
         @(posedge clock);
         queue_random_words(PHASE_WORDS);
         wait_drained();
      end

      if (bad_events == 0 && predicted_events.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
